FILE: rtl/sbfd_pkg.sv
// -----------------------------------------------------------------------------
// sbfd_pkg
// Shared types and constants for the sync byte fixed frame deframer.
// -----------------------------------------------------------------------------
package sbfd_pkg;

   localparam int MAX_FRAME_DEFAULT = 12;

   // wide enough to compare any 4-bit length against any frame size up to 16
   localparam int CMP_W = 5;

   localparam logic [7:0] SYNC_BYTE_RESET    = 8'h61;
   localparam logic [3:0] SHORT_LENGTH_RESET = 4'd5;
   localparam logic [3:0] LONG_LENGTH_RESET  = 4'd12;

   typedef enum logic [1:0] {
      CSR_SHORT_MODE   = 2'd0,
      CSR_SYNC_BYTE    = 2'd1,
      CSR_SHORT_LENGTH = 2'd2,
      CSR_LONG_LENGTH  = 2'd3
   } csr_index_type;

   // front to frame queue: one stored byte, done marks frame completion
   typedef struct packed {
      logic       en;
      logic       done;
      logic [7:0] data;
   } fwr_type;

endpackage

FILE: rtl/sbfd_front.sv
// -----------------------------------------------------------------------------
// sbfd_front
// Holds the configuration, tracks the byte position and classifies each
// received word: dropped, frame restart, or data; flags frame completion.
// -----------------------------------------------------------------------------
module sbfd_front #(
   parameter int MAX_FRAME = sbfd_pkg::MAX_FRAME_DEFAULT,
   parameter int POS_W     = $clog2(MAX_FRAME),
   parameter int LEN_W     = $clog2(MAX_FRAME + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  sbfd_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   output logic                   in_ready,
   input  logic                   q_full,
   output sbfd_pkg::fwr_type      wr,
   output logic [POS_W-1:0]       wr_idx,
   output logic [LEN_W-1:0]       wr_len
);

   localparam int CW = sbfd_pkg::CMP_W;

   logic             short_mode_ff, short_mode_in;
   logic [7:0]       sync_byte_ff, sync_byte_in;
   logic [3:0]       short_len_ff, short_len_in;
   logic [3:0]       long_len_ff, long_len_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [3:0]    sel_len;
   logic [CW-1:0] len_c;
   logic [CW-1:0] p;
   logic [CW-1:0] np;
   logic [CW-1:0] widx;
   logic          is_sync;
   logic          accept;
   logic          store;
   logic          done;

   always_comb begin
      sel_len = short_mode_ff ? short_len_ff : long_len_ff;
      len_c   = {1'b0, sel_len};
      if (len_c < CW'(2)) begin
         len_c = CW'(2);
      end else if (len_c > CW'(MAX_FRAME)) begin
         len_c = CW'(MAX_FRAME);
      end

      p       = (CW'(pos_ff) >= len_c) ? '0 : CW'(pos_ff);
      is_sync = (in_byte == sync_byte_ff);
      accept  = in_valid && !q_full;

      store = 1'b1;
      widx  = p;
      np    = p + CW'(1);
      if (p == '0) begin
         store = is_sync;
         widx  = '0;
         np    = is_sync ? CW'(1) : '0;
      end else if (is_sync && (!short_mode_ff || (p < len_c - CW'(1)))) begin
         widx = '0;
         np   = CW'(1);
      end
      done = accept && (np == len_c);
   end

   assign in_ready = !q_full;
   assign wr.en    = accept && store;
   assign wr.done  = done;
   assign wr.data  = in_byte;
   assign wr_idx   = POS_W'(widx);
   assign wr_len   = LEN_W'(len_c);

   always_comb begin
      short_mode_in = short_mode_ff;
      sync_byte_in  = sync_byte_ff;
      short_len_in  = short_len_ff;
      long_len_in   = long_len_ff;
      pos_in        = pos_ff;
      if (csr_we) begin
         unique case (csr_index)
            sbfd_pkg::CSR_SHORT_MODE: begin
               short_mode_in = csr_wdata[0];
               pos_in        = '0;
            end
            sbfd_pkg::CSR_SYNC_BYTE:    sync_byte_in = csr_wdata;
            sbfd_pkg::CSR_SHORT_LENGTH: short_len_in = csr_wdata[3:0];
            sbfd_pkg::CSR_LONG_LENGTH:  long_len_in  = csr_wdata[3:0];
            default: ;
         endcase
      end else if (accept) begin
         pos_in = done ? '0 : POS_W'(np);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_mode_ff <= 1'b0;
         sync_byte_ff  <= sbfd_pkg::SYNC_BYTE_RESET;
         short_len_ff  <= sbfd_pkg::SHORT_LENGTH_RESET;
         long_len_ff   <= sbfd_pkg::LONG_LENGTH_RESET;
         pos_ff        <= '0;
      end else begin
         short_mode_ff <= short_mode_in;
         sync_byte_ff  <= sync_byte_in;
         short_len_ff  <= short_len_in;
         long_len_ff   <= long_len_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

FILE: rtl/sbfd_frame_q.sv
// -----------------------------------------------------------------------------
// sbfd_frame_q
// Two-slot frame queue: the front fills one slot while the back drains the
// other. Each slot holds the frame bytes and the frame length.
// -----------------------------------------------------------------------------
module sbfd_frame_q #(
   parameter int MAX_FRAME = sbfd_pkg::MAX_FRAME_DEFAULT,
   parameter int POS_W     = $clog2(MAX_FRAME),
   parameter int LEN_W     = $clog2(MAX_FRAME + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  sbfd_pkg::fwr_type wr,
   input  logic [POS_W-1:0]  wr_idx,
   input  logic [LEN_W-1:0]  wr_len,
   output logic              full,
   input  logic [POS_W-1:0]  rd_idx,
   input  logic              pop,
   output logic              head_valid,
   output logic [LEN_W-1:0]  head_len,
   output logic [7:0]        rd_data,
   output logic [1:0]        level
);

   logic [7:0]       store_ff [2][MAX_FRAME];
   logic [LEN_W-1:0] len_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_len   = len_ff[rd_ptr_ff];
   assign rd_data    = store_ff[rd_ptr_ff][rd_idx];
   assign level      = count_ff;

   always_comb begin
      wr_ptr_in = wr.done ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(wr.done) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr_ptr_ff][wr_idx] <= wr.data;
      end
      if (wr.done) begin
         len_ff[wr_ptr_ff] <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/sbfd_back.sv
// -----------------------------------------------------------------------------
// sbfd_back
// Drains the head frame into the output register, one word per cycle while the
// receiver accepts each word, and marks the final byte.
// -----------------------------------------------------------------------------
module sbfd_back #(
   parameter int MAX_FRAME = sbfd_pkg::MAX_FRAME_DEFAULT,
   parameter int POS_W     = $clog2(MAX_FRAME),
   parameter int LEN_W     = $clog2(MAX_FRAME + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  logic [LEN_W-1:0] head_len,
   input  logic [7:0]       rd_data,
   output logic [POS_W-1:0] rd_idx,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_end
);

   logic [POS_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   logic             load;
   logic             last;

   always_comb begin
      load     = head_valid && (!valid_ff || out_ready);
      last     = (LEN_W'(idx_ff) == head_len - LEN_W'(1));
      pop      = load && last;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (load) begin
         idx_in   = last ? '0 : idx_ff + POS_W'(1);
         valid_in = 1'b1;
         byte_in  = rd_data;
         end_in   = last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   assign rd_idx    = idx_ff;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/sync_byte_fixed_frame_deframer.sv
// -----------------------------------------------------------------------------
// sync_byte_fixed_frame_deframer
// Frames fixed-length commands that start with a sync byte.
// -----------------------------------------------------------------------------
// req_ channel: one received byte per word. Bytes are dropped until the sync
// byte arrives; a frame completes when it reaches the short or long length.
// rsp_ channel: the completed frame, one byte per word in order, with
// rsp_frame_end high on the final byte.
// csr_ port: write-only registers 0 short_mode, 1 sync_byte, 2 short_length,
// 3 long_length. Writing short_mode clears the byte position.
// Throughput: one req_ word per cycle while the frame queue has a free slot;
// output drains at one word per cycle while rsp_ready holds. The two-slot frame
// queue lets the front collect a frame while the back drains the previous one.
// Output path: a frame's last accepted byte is registered in the queue count;
// from an empty queue, the output register then loads its first byte.
// Reset: registers return to defaults, position and queue clear.
// Receiver stall: the output word holds; once both slots hold frames,
// req_ready drops until the back finishes a frame.
// -----------------------------------------------------------------------------
module sync_byte_fixed_frame_deframer #(
   parameter int MAX_FRAME = sbfd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  sbfd_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_frame_end
);

   localparam int POS_W = $clog2(MAX_FRAME);
   localparam int LEN_W = $clog2(MAX_FRAME + 1);

   sbfd_pkg::fwr_type wr;
   logic [POS_W-1:0]  wr_idx;
   logic [LEN_W-1:0]  wr_len;
   logic              q_full;
   logic [POS_W-1:0]  rd_idx;
   logic              pop;
   logic              head_valid;
   logic [LEN_W-1:0]  head_len;
   logic [7:0]        rd_data;
   logic [1:0]        q_level;

   sbfd_front #(
      .MAX_FRAME(MAX_FRAME),
      .POS_W    (POS_W),
      .LEN_W    (LEN_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_valid (req_valid),
      .in_byte  (req_rx_byte),
      .in_ready (req_ready),
      .q_full   (q_full),
      .wr       (wr),
      .wr_idx   (wr_idx),
      .wr_len   (wr_len)
   );

   sbfd_frame_q #(
      .MAX_FRAME(MAX_FRAME),
      .POS_W    (POS_W),
      .LEN_W    (LEN_W)
   ) u_frame_q (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .wr_idx    (wr_idx),
      .wr_len    (wr_len),
      .full      (q_full),
      .rd_idx    (rd_idx),
      .pop       (pop),
      .head_valid(head_valid),
      .head_len  (head_len),
      .rd_data   (rd_data),
      .level     (q_level)
   );

   sbfd_back #(
      .MAX_FRAME(MAX_FRAME),
      .POS_W    (POS_W),
      .LEN_W    (LEN_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_len  (head_len),
      .rd_data   (rd_data),
      .rd_idx    (rd_idx),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_byte  (rsp_frame_byte),
      .out_end   (rsp_frame_end)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      wr.done |-> (q_level != 2'd2))
      else $error("frame pushed into full queue");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level != 2'd3)
      else $error("frame queue level out of range");

   a_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (LEN_W'(rd_idx) < head_len))
      else $error("read index past frame length");

   a_pop_marks_end: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_frame_end))
      else $error("frame drained without end mark");

endmodule
